// File: hw/rtl/vtn_pkg.sv
// shared widths, field types and register codes of the vertex transform core
// no dependencies
package vtn_pkg;

  localparam int POS_W  = 24;  // q11.12 position
  localparam int NRM_W  = 16;  // q1.14 normal
  localparam int ENT_W  = 20;  // q3.16 matrix entry
  localparam int COL_W  = 60;  // three packed entries
  localparam int MAG_W  = 36;  // magnitude of a transformed normal
  localparam int A_W    = 30;  // normalized magnitude
  localparam int SQ_W   = 62;  // sum of squares
  localparam int LEN_W  = 31;  // integer square root
  localparam int NUM_W  = 46;  // divider numerator and remainder
  localparam int Q_W    = 15;  // quotient bits
  localparam int IDX_W  = 3;

  localparam logic [IDX_W-1:0] REG_COL0     = 3'd0;
  localparam logic [IDX_W-1:0] REG_COL1     = 3'd1;
  localparam logic [IDX_W-1:0] REG_COL2     = 3'd2;
  localparam logic [IDX_W-1:0] REG_COL3     = 3'd3;
  localparam logic [IDX_W-1:0] REG_USE_VCOL = 3'd4;
  localparam logic [IDX_W-1:0] REG_USE_ISOA = 3'd5;
  localparam logic [IDX_W-1:0] REG_ISO      = 3'd6;

  localparam logic [COL_W-1:0] COL0_RST = 60'd65536;
  localparam logic [COL_W-1:0] COL1_RST = 60'd65536 << 20;
  localparam logic [COL_W-1:0] COL2_RST = 60'd65536 << 40;
  localparam logic [COL_W-1:0] COL3_RST = 60'd0;
  localparam logic [31:0]      ISO_RST  = 32'hFFFF_FFFF;

  // data that rides alongside the normal path
  typedef struct packed {
    logic signed [POS_W-1:0] x;
    logic signed [POS_W-1:0] y;
    logic signed [POS_W-1:0] z;
    logic                    sat;
    logic [31:0]             rgba;
    logic [2:0]              neg;
    logic                    zero;
  } side_t;

  typedef logic [A_W-1:0]   amag_t;
  typedef logic [MAG_W-1:0] mag_t;

endpackage

// File: hw/rtl/vtn_xform.sv
// matrix multiply of position and normal: products, sums, rounding and clipping
// depends on vtn_pkg
module vtn_xform (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              en,
  input  logic                              in_valid,
  input  logic signed [vtn_pkg::POS_W-1:0]  pos [3],
  input  logic signed [vtn_pkg::NRM_W-1:0]  nrm [3],
  input  logic [31:0]                       rgba,
  input  logic [vtn_pkg::COL_W-1:0]         cols [4],
  output logic                              out_valid,
  output vtn_pkg::side_t                    side,
  output vtn_pkg::mag_t                     mag [3]
);

  logic               v1_r, v2_r, v3_r;
  logic signed [43:0] pp_r [3][3];
  logic signed [35:0] pn_r [3][3];
  logic signed [31:0] tr_r [3];
  logic [31:0]        c1_r, c2_r;
  logic signed [45:0] acc_r [3];
  logic signed [37:0] t_r [3];
  vtn_pkg::side_t     side_r, side_nxt;
  vtn_pkg::mag_t      mag_r [3], mag_nxt [3];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else if (en) begin
      v1_r <= in_valid;
      v2_r <= v1_r;
      v3_r <= v2_r;
    end
  end

  // stage 1: all products
  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        for (int j = 0; j < 3; j++) begin
          pp_r[i][j] <= $signed(cols[j][20*i +: 20]) * pos[j];
          pn_r[i][j] <= $signed(cols[j][20*i +: 20]) * nrm[j];
        end
        tr_r[i] <= $signed({cols[3][20*i +: 20], 12'b0});
      end
      c1_r <= rgba;
    end
  end

  // stage 2: row sums
  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        acc_r[i] <= 46'(pp_r[i][0]) + 46'(pp_r[i][1]) + 46'(pp_r[i][2]) + 46'(tr_r[i]);
        t_r[i]   <= 38'(pn_r[i][0]) + 38'(pn_r[i][1]) + 38'(pn_r[i][2]);
      end
      c2_r <= c1_r;
    end
  end

  // stage 3: round, clip, magnitudes
  always_comb begin
    logic signed [45:0] rnd;
    logic signed [29:0] r [3];
    logic signed [vtn_pkg::POS_W-1:0] c [3];
    logic sat;
    sat = 1'b0;
    for (int i = 0; i < 3; i++) begin
      rnd  = acc_r[i] + 46'sd32768;
      r[i] = rnd[45:16];
      if (r[i] > 30'sd8388607) begin
        c[i] = 24'sh7FFFFF;
        sat  = 1'b1;
      end else if (r[i] < -30'sd8388608) begin
        c[i] = 24'sh800000;
        sat  = 1'b1;
      end else begin
        c[i] = r[i][23:0];
      end
      side_nxt.neg[i] = t_r[i][37];
      mag_nxt[i] = t_r[i][37] ? 36'(-t_r[i]) : 36'(t_r[i]);
    end
    side_nxt.x    = c[0];
    side_nxt.y    = c[1];
    side_nxt.z    = c[2];
    side_nxt.sat  = sat;
    side_nxt.rgba = c2_r;
    side_nxt.zero = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      side_r <= side_nxt;
      mag_r  <= mag_nxt;
    end
  end

  assign out_valid = v3_r;
  assign side      = side_r;
  assign mag       = mag_r;

endmodule

// File: hw/rtl/vtn_prep.sv
// normal scaling to a common exponent, squares and their sum
// depends on vtn_pkg
module vtn_prep (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        en,
  input  logic                        in_valid,
  input  vtn_pkg::side_t              in_side,
  input  vtn_pkg::mag_t               in_mag [3],
  output logic                        out_valid,
  output vtn_pkg::side_t              side,
  output vtn_pkg::amag_t              amag [3],
  output logic [vtn_pkg::SQ_W-1:0]    sumsq
);

  logic [4:0]            vld_r;
  vtn_pkg::side_t        sa_r, sb_r, sc_r, sd_r, se_r;
  vtn_pkg::side_t        sb_nxt;
  vtn_pkg::mag_t         ma_r [3], mb_r [3];
  logic [vtn_pkg::MAG_W-1:0] mx_r;
  logic [5:0]            top_r;
  vtn_pkg::amag_t        ac_r [3], ad_r [3], ae_r [3];
  logic [59:0]           sq_r [3];
  logic [vtn_pkg::SQ_W-1:0] sum_r;
  logic [5:0]            top_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[3:0], in_valid};
    end
  end

  // a: largest magnitude
  always_ff @(posedge clk) begin
    if (en) begin
      ma_r <= in_mag;
      sa_r <= in_side;
      if (in_mag[0] >= in_mag[1] && in_mag[0] >= in_mag[2]) mx_r <= in_mag[0];
      else if (in_mag[1] >= in_mag[2]) mx_r <= in_mag[1];
      else mx_r <= in_mag[2];
    end
  end

  // b: leading one position
  always_comb begin
    top_nxt = '0;
    for (int k = 0; k < vtn_pkg::MAG_W; k++) begin
      if (mx_r[k]) top_nxt = 6'(k);
    end
  end

  always_comb begin
    sb_nxt      = sa_r;
    sb_nxt.zero = (mx_r == '0);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      mb_r <= ma_r;
      sb_r <= sb_nxt;
      top_r <= top_nxt;
    end
  end

  // c: shift so the largest sits in [2^29, 2^30)
  always_ff @(posedge clk) begin
    if (en) begin
      sc_r <= sb_r;
      for (int i = 0; i < 3; i++) begin
        if (top_r > 6'(vtn_pkg::A_W - 1)) ac_r[i] <= 30'(mb_r[i] >> (top_r - 6'd29));
        else ac_r[i] <= 30'(mb_r[i] << (6'd29 - top_r));
      end
    end
  end

  // d: squares
  always_ff @(posedge clk) begin
    if (en) begin
      sd_r <= sc_r;
      ad_r <= ac_r;
      for (int i = 0; i < 3; i++) sq_r[i] <= 60'(ac_r[i]) * 60'(ac_r[i]);
    end
  end

  // e: sum
  always_ff @(posedge clk) begin
    if (en) begin
      se_r  <= sd_r;
      ae_r  <= ad_r;
      sum_r <= 62'(sq_r[0]) + 62'(sq_r[1]) + 62'(sq_r[2]);
    end
  end

  assign out_valid = vld_r[4];
  assign side      = se_r;
  assign amag      = ae_r;
  assign sumsq     = sum_r;

endmodule

// File: hw/rtl/vtn_sqrt.sv
// pipelined integer square root, one result bit per stage
// depends on vtn_pkg
module vtn_sqrt (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       en,
  input  logic                       in_valid,
  input  vtn_pkg::side_t             in_side,
  input  vtn_pkg::amag_t             in_amag [3],
  input  logic [vtn_pkg::SQ_W-1:0]   sumsq,
  output logic                       out_valid,
  output vtn_pkg::side_t             side,
  output vtn_pkg::amag_t             amag [3],
  output logic [vtn_pkg::LEN_W-1:0]  len
);

  localparam int N = vtn_pkg::LEN_W;

  logic           vld_r [N];
  logic [63:0]    rem_r [N];
  logic [63:0]    root_r [N];
  vtn_pkg::side_t side_r [N];
  vtn_pkg::amag_t am_r [N][3];

  for (genvar k = 0; k < N; k++) begin : g_stage
    localparam int SH = 2 * (N - 1 - k);
    logic [63:0]    rem_p, root_p, trial, rem_nxt, root_nxt;
    logic           vld_p;
    vtn_pkg::side_t side_p;
    vtn_pkg::amag_t am_p [3];

    if (k == 0) begin : g_first
      assign rem_p  = 64'(sumsq);
      assign root_p = '0;
      assign vld_p  = in_valid;
      assign side_p = in_side;
      assign am_p   = in_amag;
    end else begin : g_rest
      assign rem_p  = rem_r[k-1];
      assign root_p = root_r[k-1];
      assign vld_p  = vld_r[k-1];
      assign side_p = side_r[k-1];
      assign am_p   = am_r[k-1];
    end

    always_comb begin
      trial = root_p + (64'd1 << SH);
      if (rem_p >= trial) begin
        rem_nxt  = rem_p - trial;
        root_nxt = (root_p >> 1) + (64'd1 << SH);
      end else begin
        rem_nxt  = rem_p;
        root_nxt = root_p >> 1;
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[k] <= 1'b0;
      end else if (en) begin
        vld_r[k] <= vld_p;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[k]  <= rem_nxt;
        root_r[k] <= root_nxt;
        side_r[k] <= side_p;
        am_r[k]   <= am_p;
      end
    end
  end

  assign out_valid = vld_r[N-1];
  assign side      = side_r[N-1];
  assign amag      = am_r[N-1];
  assign len       = root_r[N-1][N-1:0];

endmodule

// File: hw/rtl/vtn_div.sv
// three lanes of pipelined rounded division by the length, then sign and zero fix
// depends on vtn_pkg
module vtn_div (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              en,
  input  logic                              in_valid,
  input  vtn_pkg::side_t                    in_side,
  input  vtn_pkg::amag_t                    in_amag [3],
  input  logic [vtn_pkg::LEN_W-1:0]         len,
  output logic                              out_valid,
  output vtn_pkg::side_t                    side,
  output logic signed [vtn_pkg::NRM_W-1:0]  nrm [3]
);

  localparam int N  = vtn_pkg::Q_W;
  localparam int NW = vtn_pkg::NUM_W;

  logic                          nv_r;
  logic [NW-1:0]                 num_r [3];
  logic [vtn_pkg::LEN_W-1:0]     nl_r;
  vtn_pkg::side_t                ns_r;

  logic                          vld_r [N];
  logic [NW-1:0]                 rem_r [N][3];
  logic [N-1:0]                  q_r [N][3];
  logic [vtn_pkg::LEN_W-1:0]     len_r [N];
  vtn_pkg::side_t                side_r [N];

  logic                          fv_r;
  vtn_pkg::side_t                fs_r;
  logic signed [vtn_pkg::NRM_W-1:0] fn_r [3];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      nv_r <= 1'b0;
      fv_r <= 1'b0;
    end else if (en) begin
      nv_r <= in_valid;
      fv_r <= vld_r[N-1];
    end
  end

  // numerator with half the divisor added for rounding
  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        num_r[i] <= NW'({in_amag[i], 14'b0}) + NW'(len >> 1);
      end
      nl_r <= len;
      ns_r <= in_side;
    end
  end

  for (genvar k = 0; k < N; k++) begin : g_stage
    localparam int SH = N - 1 - k;
    logic [NW-1:0]             rem_p [3];
    logic [N-1:0]              q_p [3];
    logic [vtn_pkg::LEN_W-1:0] len_p;
    vtn_pkg::side_t            side_p;
    logic                      vld_p;
    logic [NW-1:0]             dv;

    if (k == 0) begin : g_first
      assign rem_p  = num_r;
      assign q_p    = '{default: '0};
      assign len_p  = nl_r;
      assign side_p = ns_r;
      assign vld_p  = nv_r;
    end else begin : g_rest
      assign rem_p  = rem_r[k-1];
      assign q_p    = q_r[k-1];
      assign len_p  = len_r[k-1];
      assign side_p = side_r[k-1];
      assign vld_p  = vld_r[k-1];
    end

    assign dv = NW'(len_p) << SH;

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[k] <= 1'b0;
      end else if (en) begin
        vld_r[k] <= vld_p;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        for (int i = 0; i < 3; i++) begin
          if (rem_p[i] >= dv) begin
            rem_r[k][i] <= rem_p[i] - dv;
            q_r[k][i]   <= q_p[i] | (N'(1) << SH);
          end else begin
            rem_r[k][i] <= rem_p[i];
            q_r[k][i]   <= q_p[i];
          end
        end
        len_r[k]  <= len_p;
        side_r[k] <= side_p;
      end
    end
  end

  // output register: sign and zero-length normal
  always_ff @(posedge clk) begin
    if (en) begin
      fs_r <= side_r[N-1];
      for (int i = 0; i < 3; i++) begin
        if (side_r[N-1].zero) fn_r[i] <= '0;
        else if (side_r[N-1].neg[i]) fn_r[i] <= -$signed({1'b0, q_r[N-1][i]});
        else fn_r[i] <= $signed({1'b0, q_r[N-1][i]});
      end
    end
  end

  assign out_valid = fv_r;
  assign side      = fs_r;
  assign nrm       = fn_r;

endmodule

// File: hw/rtl/vertex_transform_normalize_core.sv
// top level of the vertex transform core: registers, colour select and pipeline
// depends on vtn_pkg, vtn_xform, vtn_prep, vtn_sqrt, vtn_div
//
//  channel | dir | handshake             | payload
//  in      | in  | in_tvalid/in_tready   | in_tdata 152 bits, one vertex
//  out     | out | out_tvalid/out_tready | out_tdata 160 bits, one result
//  cfg     | in  | cfg_we                | cfg_index 3 bits, cfg_data 60 bits
//
// one item per cycle while the pipeline is not held; an item passes from acceptance
// through transform, scaling, square root, numerator, divide and output to out_tvalid
// the whole pipeline moves together: it holds while out_tvalid is high and
// out_tready is low, and in_tready follows that same condition
// synchronous active-low reset clears the valid bits and loads the identity matrix
module vertex_transform_normalize_core (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_tvalid,
  output logic                        in_tready,
  // pos_x, pos_y, pos_z, norm_x, norm_y, norm_z, red_in, green_in, blue_in, alpha_in
  input  logic [151:0]                in_tdata,
  output logic                        out_tvalid,
  input  logic                        out_tready,
  // out_x, out_y, out_z, out_nx, out_ny, out_nz, red_out, green_out, blue_out,
  // alpha_out, saturated, zero fill
  output logic [159:0]                out_tdata,
  input  logic                        cfg_we,
  input  logic [vtn_pkg::IDX_W-1:0]   cfg_index,
  input  logic [vtn_pkg::COL_W-1:0]   cfg_data
);

  logic [vtn_pkg::COL_W-1:0] col_r [4];
  logic                      use_vcol_r, use_isoa_r;
  logic [31:0]               iso_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r[0]   <= vtn_pkg::COL0_RST;
      col_r[1]   <= vtn_pkg::COL1_RST;
      col_r[2]   <= vtn_pkg::COL2_RST;
      col_r[3]   <= vtn_pkg::COL3_RST;
      use_vcol_r <= 1'b0;
      use_isoa_r <= 1'b0;
      iso_r      <= vtn_pkg::ISO_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        vtn_pkg::REG_COL0:     col_r[0]   <= cfg_data;
        vtn_pkg::REG_COL1:     col_r[1]   <= cfg_data;
        vtn_pkg::REG_COL2:     col_r[2]   <= cfg_data;
        vtn_pkg::REG_COL3:     col_r[3]   <= cfg_data;
        vtn_pkg::REG_USE_VCOL: use_vcol_r <= cfg_data[0];
        vtn_pkg::REG_USE_ISOA: use_isoa_r <= cfg_data[0];
        vtn_pkg::REG_ISO:      iso_r      <= cfg_data[31:0];
        default: ;
      endcase
    end
  end

  logic en;
  logic signed [vtn_pkg::POS_W-1:0] pos [3];
  logic signed [vtn_pkg::NRM_W-1:0] nrm [3];
  logic [31:0] rgba;

  assign en = !out_tvalid || out_tready;
  assign in_tready = en;

  assign pos[0] = in_tdata[23:0];
  assign pos[1] = in_tdata[47:24];
  assign pos[2] = in_tdata[71:48];
  assign nrm[0] = in_tdata[87:72];
  assign nrm[1] = in_tdata[103:88];
  assign nrm[2] = in_tdata[119:104];

  always_comb begin
    if (!use_vcol_r) rgba = iso_r;
    else if (use_isoa_r) rgba = {in_tdata[127:120], in_tdata[135:128], in_tdata[143:136], iso_r[7:0]};
    else rgba = {in_tdata[127:120], in_tdata[135:128], in_tdata[143:136], in_tdata[151:144]};
  end

  logic           xv, pv, sv, dv;
  vtn_pkg::side_t xs, ps, ss, ds;
  vtn_pkg::mag_t  xm [3];
  vtn_pkg::amag_t pa [3], sa [3];
  logic [vtn_pkg::SQ_W-1:0]  psum;
  logic [vtn_pkg::LEN_W-1:0] slen;
  logic signed [vtn_pkg::NRM_W-1:0] dn [3];

  vtn_xform u_xform (
    .clk, .rst_n, .en, .in_valid(in_tvalid && in_tready), .pos, .nrm, .rgba,
    .cols(col_r), .out_valid(xv), .side(xs), .mag(xm)
  );

  vtn_prep u_prep (
    .clk, .rst_n, .en, .in_valid(xv), .in_side(xs), .in_mag(xm),
    .out_valid(pv), .side(ps), .amag(pa), .sumsq(psum)
  );

  vtn_sqrt u_sqrt (
    .clk, .rst_n, .en, .in_valid(pv), .in_side(ps), .in_amag(pa), .sumsq(psum),
    .out_valid(sv), .side(ss), .amag(sa), .len(slen)
  );

  vtn_div u_div (
    .clk, .rst_n, .en, .in_valid(sv), .in_side(ss), .in_amag(sa), .len(slen),
    .out_valid(dv), .side(ds), .nrm(dn)
  );

  assign out_tvalid = dv;
  assign out_tdata  = {7'b0, ds.sat, ds.rgba[7:0], ds.rgba[15:8], ds.rgba[23:16],
                       ds.rgba[31:24], dn[2], dn[1], dn[0], ds.z, ds.y, ds.x};

endmodule

// File: hw/rtl/vtn_checker.sv
// port-level checks for the vertex transform core, bound to the top level
// depends on vertex_transform_normalize_core
module vtn_checker (
  input logic         clk,
  input logic         rst_n,
  input logic         in_tvalid,
  input logic         in_tready,
  input logic         out_tvalid,
  input logic         out_tready,
  input logic [159:0] out_tdata
);

  // the pipeline holds exactly while a result waits
  a_ready: assert property (@(posedge clk) disable iff (!rst_n)
    in_tready == (!out_tvalid || out_tready))
    else $error("in_tready does not follow output stall");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("stalled result changed");

  a_rst: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

  a_pad: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[159:153] == 7'd0)
    else $error("fill bits set");

  // the x component of the normal never exceeds one in magnitude
  a_unit: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> ($signed(out_tdata[87:72]) <= 16'sd16384 &&
                    $signed(out_tdata[87:72]) >= -16'sd16384))
    else $error("normal x out of unit range");

endmodule

bind vertex_transform_normalize_core vtn_checker u_vtn_checker (
  .clk, .rst_n, .in_tvalid, .in_tready, .out_tvalid, .out_tready, .out_tdata
);
